// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When the condition holds, the consequence must hold in the same cycle.
`define ASSERT_SAME_CYCLE(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("same-cycle check failed");

// When the condition holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT_CYCLE(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/iurhp_pkg.sv =====
`timescale 1ns / 1ps

package iurhp_pkg;

   // Default width of the saturating byte counter.
   localparam int DEFAULT_COUNTER_BITS = 16;

   // Header geometry, in bytes.
   localparam int RTP_HEADER_BYTES  = 12;
   localparam int ETH_BYTES         = 14;
   localparam int ETHERTYPE_OFFSET  = 12;
   localparam int PROTOCOL_OFFSET   = 9;
   localparam int ADDR_START        = 12;
   localparam int ADDR_SPLIT        = 16;
   localparam int ADDR_END          = 20;
   localparam int PORT_BASE_PLAIN   = 20;
   localparam int PORT_BASE_OPTIONS = 28;
   localparam int PORT_BYTES        = 4;
   localparam int RTP_START         = 28;
   localparam int MIN_IP_BYTES      = RTP_START + RTP_HEADER_BYTES;

   // Field values checked in the headers.
   localparam logic [7:0] ETHERTYPE_HI   = 8'h08;
   localparam logic [7:0] ETHERTYPE_LO   = 8'h00;
   localparam logic [7:0] UDP_PROTOCOL   = 8'h11;
   localparam logic [3:0] IHL_NO_OPTIONS = 4'h5;

   // Register file geometry.
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_DATA_BITS-1:0] MAX_PAYLOAD_RESET = 16'hFFFF;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_STRIP_ETHERNET,
      CSR_MAX_PAYLOAD
   } csr_index_type;

   typedef enum logic [2:0] {
      STATUS_OK,
      STATUS_BAD_ETHERTYPE,
      STATUS_TOO_SHORT,
      STATUS_NOT_UDP,
      STATUS_BAD_LENGTH
   } status_type;

   // Header fields gathered while a packet streams through.
   typedef struct packed {
      logic                              ethertype_ok;
      logic [7:0]                        protocol_byte;
      logic [1:0][31:0]                  address_words;
      logic [1:0][15:0]                  port_words;
      logic [RTP_HEADER_BYTES-1:0][7:0]  rtp_bytes;
   } packet_fields_type;

endpackage

// ===== rtl/iurhp_capture.sv =====
`timescale 1ns / 1ps

module iurhp_capture #(
   parameter int COUNTER_BITS = iurhp_pkg::DEFAULT_COUNTER_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [7:0]                    data_byte,
   input  logic                          last_byte,
   input  logic                          strip_ethernet,
   output logic [COUNTER_BITS-1:0]       count_next,
   output iurhp_pkg::packet_fields_type  fields_next
);

   localparam logic [COUNTER_BITS-1:0] COUNT_MAX    = '1;
   localparam logic [COUNTER_BITS-1:0] OFF_ETH      = COUNTER_BITS'(iurhp_pkg::ETH_BYTES);
   localparam logic [COUNTER_BITS-1:0] OFF_ETYPE    =
      COUNTER_BITS'(iurhp_pkg::ETHERTYPE_OFFSET);
   localparam logic [COUNTER_BITS-1:0] OFF_ETYPE_LO =
      COUNTER_BITS'(iurhp_pkg::ETHERTYPE_OFFSET + 1);
   localparam logic [COUNTER_BITS-1:0] OFF_PROTO    =
      COUNTER_BITS'(iurhp_pkg::PROTOCOL_OFFSET);
   localparam logic [COUNTER_BITS-1:0] OFF_ADDR     = COUNTER_BITS'(iurhp_pkg::ADDR_START);
   localparam logic [COUNTER_BITS-1:0] OFF_ADDR_MID = COUNTER_BITS'(iurhp_pkg::ADDR_SPLIT);
   localparam logic [COUNTER_BITS-1:0] OFF_ADDR_END = COUNTER_BITS'(iurhp_pkg::ADDR_END);
   localparam logic [COUNTER_BITS-1:0] OFF_PORT_PL  =
      COUNTER_BITS'(iurhp_pkg::PORT_BASE_PLAIN);
   localparam logic [COUNTER_BITS-1:0] OFF_PORT_OPT =
      COUNTER_BITS'(iurhp_pkg::PORT_BASE_OPTIONS);
   localparam logic [COUNTER_BITS-1:0] PORT_LEN     = COUNTER_BITS'(iurhp_pkg::PORT_BYTES);
   localparam logic [COUNTER_BITS-1:0] PORT_HALF    =
      COUNTER_BITS'(iurhp_pkg::PORT_BYTES / 2);
   localparam logic [COUNTER_BITS-1:0] OFF_RTP      = COUNTER_BITS'(iurhp_pkg::RTP_START);

   logic [COUNTER_BITS-1:0]       byte_position_ff;
   logic                          options_present_ff;
   logic                          options_present_in;
   iurhp_pkg::packet_fields_type  fields_ff;
   iurhp_pkg::packet_fields_type  fields_in;

   logic [COUNTER_BITS-1:0] base;
   logic [COUNTER_BITS-1:0] offset;
   logic [COUNTER_BITS-1:0] port_base;
   logic                    in_ip;

   // Decode the current byte against its position and update the captured fields.
   always_comb begin
      base               = strip_ethernet ? OFF_ETH : '0;
      in_ip              = byte_position_ff >= base;
      offset             = byte_position_ff - base;
      port_base          = options_present_ff ? OFF_PORT_OPT : OFF_PORT_PL;
      fields_in          = fields_ff;
      options_present_in = options_present_ff;

      if (strip_ethernet) begin
         if (byte_position_ff == OFF_ETYPE) begin
            fields_in.ethertype_ok = (data_byte == iurhp_pkg::ETHERTYPE_HI);
         end else if (byte_position_ff == OFF_ETYPE_LO) begin
            fields_in.ethertype_ok = fields_ff.ethertype_ok &&
                                     (data_byte == iurhp_pkg::ETHERTYPE_LO);
         end
      end

      if (in_ip) begin
         if (offset == '0) begin
            options_present_in = (data_byte[3:0] > iurhp_pkg::IHL_NO_OPTIONS);
         end
         if (offset == OFF_PROTO) begin
            fields_in.protocol_byte = data_byte;
         end
         if ((offset >= OFF_ADDR) && (offset < OFF_ADDR_END)) begin
            if (offset < OFF_ADDR_MID) begin
               fields_in.address_words[0] = {fields_ff.address_words[0][23:0], data_byte};
            end else begin
               fields_in.address_words[1] = {fields_ff.address_words[1][23:0], data_byte};
            end
         end
         if ((offset >= port_base) && (offset < port_base + PORT_LEN)) begin
            if (offset < port_base + PORT_HALF) begin
               fields_in.port_words[0] = {fields_ff.port_words[0][7:0], data_byte};
            end else begin
               fields_in.port_words[1] = {fields_ff.port_words[1][7:0], data_byte};
            end
         end
         for (int k = 0; k < iurhp_pkg::RTP_HEADER_BYTES; k++) begin
            if (offset == OFF_RTP + COUNTER_BITS'(k)) begin
               fields_in.rtp_bytes[k] = data_byte;
            end
         end
      end

      // The counter sticks at its maximum on very long packets.
      count_next  = (byte_position_ff == COUNT_MAX) ? byte_position_ff
                                                    : byte_position_ff + 1'b1;
      fields_next = fields_in;
   end

   // Packet state returns to zero after every final byte.
   always_ff @(posedge clock) begin
      if (reset || (accept && last_byte)) begin
         byte_position_ff   <= '0;
         options_present_ff <= 1'b0;
         fields_ff          <= '0;
      end else if (accept) begin
         byte_position_ff   <= count_next;
         options_present_ff <= options_present_in;
         fields_ff          <= fields_in;
      end
   end

endmodule

// ===== rtl/ipv4_udp_rtp_header_parser.sv =====
`timescale 1ns / 1ps

// IPv4 / UDP / RTP header parser.
// Packet bytes arrive on the req_ channel, one per request, in wire order, with
// req_last_byte marking the final byte. One result per packet leaves on the rsp_
// channel: a status code and the captured IP, UDP and RTP header fields, all zero
// unless the status is OK. Both channels use valid/ready.
// Throughput is one byte per cycle unless a final byte waits: each byte is decoded
// by a position compare and captured straight into the header registers on accept.
// Latency: the result is valid in the cycle after the final byte is accepted.
// The csr_ port writes strip_ethernet (index 0) and max_payload_bytes (index 1)
// with no wait states.
// Reset clears the byte counter and captured fields, drops any pending result,
// and sets strip_ethernet to 0 and max_payload_bytes to 65535.
// When the receiver stalls, the result is held in the output register; bytes
// other than the final one are still accepted, and only the final byte of the
// next packet waits until the held result has been taken.
module ipv4_udp_rtp_header_parser #(
   parameter int COUNTER_BITS = iurhp_pkg::DEFAULT_COUNTER_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_last_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [2:0]                           rsp_status,
   output logic [31:0]                          rsp_source_ip,
   output logic [31:0]                          rsp_dest_ip,
   output logic [15:0]                          rsp_source_port,
   output logic [15:0]                          rsp_dest_port,
   output logic [1:0]                           rsp_rtp_version,
   output logic [2:0]                           rsp_rtp_flag_bits,
   output logic [3:0]                           rsp_contrib_count,
   output logic [6:0]                           rsp_media_type,
   output logic [15:0]                          rsp_seq_number,
   output logic [31:0]                          rsp_rtp_timestamp,
   output logic [31:0]                          rsp_rtp_offset,
   input  logic                                 csr_write_enable,
   input  logic [iurhp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [iurhp_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int CMP_BITS = (COUNTER_BITS > iurhp_pkg::CSR_DATA_BITS) ?
                             COUNTER_BITS : iurhp_pkg::CSR_DATA_BITS;
   localparam logic [COUNTER_BITS-1:0] OFF_ETH = COUNTER_BITS'(iurhp_pkg::ETH_BYTES);
   localparam logic [COUNTER_BITS-1:0] MIN_IP  = COUNTER_BITS'(iurhp_pkg::MIN_IP_BYTES);

   logic                                strip_ethernet_ff;
   logic [iurhp_pkg::CSR_DATA_BITS-1:0] max_payload_ff;

   logic                          req_accept;
   logic                          last_accept;
   logic [COUNTER_BITS-1:0]       count_next;
   iurhp_pkg::packet_fields_type  fields_next;

   logic [COUNTER_BITS-1:0]       base;
   logic [COUNTER_BITS-1:0]       ip_count;
   logic [COUNTER_BITS-1:0]       payload_len;
   iurhp_pkg::status_type         status;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [2:0]  status_ff;
   logic [31:0] source_ip_ff;
   logic [31:0] dest_ip_ff;
   logic [15:0] source_port_ff;
   logic [15:0] dest_port_ff;
   logic [1:0]  rtp_version_ff;
   logic [2:0]  rtp_flag_bits_ff;
   logic [3:0]  contrib_count_ff;
   logic [6:0]  media_type_ff;
   logic [15:0] seq_number_ff;
   logic [31:0] rtp_timestamp_ff;
   logic [31:0] rtp_offset_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         strip_ethernet_ff <= 1'b0;
         max_payload_ff    <= iurhp_pkg::MAX_PAYLOAD_RESET;
      end else if (csr_write_enable) begin
         unique case (iurhp_pkg::csr_index_type'(csr_index))
            iurhp_pkg::CSR_STRIP_ETHERNET: strip_ethernet_ff <= csr_write_data[0];
            iurhp_pkg::CSR_MAX_PAYLOAD:    max_payload_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Only a final byte needs the output register, so only it waits on a held result.
   assign req_ready   = !rsp_valid_ff || rsp_ready || !req_last_byte;
   assign req_accept  = req_valid && req_ready;
   assign last_accept = req_accept && req_last_byte;

   iurhp_capture #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_capture (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .data_byte      (req_data_byte),
      .last_byte      (req_last_byte),
      .strip_ethernet (strip_ethernet_ff),
      .count_next     (count_next),
      .fields_next    (fields_next)
   );

   // Packet checks, in priority order.
   always_comb begin
      base        = strip_ethernet_ff ? OFF_ETH : '0;
      ip_count    = count_next - base;
      payload_len = ip_count - MIN_IP;
      if (strip_ethernet_ff && ((count_next < OFF_ETH) || !fields_next.ethertype_ok)) begin
         status = iurhp_pkg::STATUS_BAD_ETHERTYPE;
      end else if (ip_count < MIN_IP) begin
         status = iurhp_pkg::STATUS_TOO_SHORT;
      end else if (fields_next.protocol_byte != iurhp_pkg::UDP_PROTOCOL) begin
         status = iurhp_pkg::STATUS_NOT_UDP;
      end else if ((payload_len == '0) ||
                   (CMP_BITS'(payload_len) > CMP_BITS'(max_payload_ff))) begin
         status = iurhp_pkg::STATUS_BAD_LENGTH;
      end else begin
         status = iurhp_pkg::STATUS_OK;
      end
   end

   // Result valid flag.
   always_comb begin
      if (last_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload; every field other than status is zero for a failed packet.
   always_ff @(posedge clock) begin
      if (last_accept) begin
         status_ff <= status;
         if (status == iurhp_pkg::STATUS_OK) begin
            source_ip_ff       <= fields_next.address_words[0];
            dest_ip_ff         <= fields_next.address_words[1];
            source_port_ff     <= fields_next.port_words[0];
            dest_port_ff       <= fields_next.port_words[1];
            rtp_version_ff     <= fields_next.rtp_bytes[0][7:6];
            rtp_flag_bits_ff   <= {fields_next.rtp_bytes[0][5:4], fields_next.rtp_bytes[1][7]};
            contrib_count_ff   <= fields_next.rtp_bytes[0][3:0];
            media_type_ff      <= fields_next.rtp_bytes[1][6:0];
            seq_number_ff      <= {fields_next.rtp_bytes[2], fields_next.rtp_bytes[3]};
            rtp_timestamp_ff   <= {fields_next.rtp_bytes[4], fields_next.rtp_bytes[5],
                                   fields_next.rtp_bytes[6], fields_next.rtp_bytes[7]};
            rtp_offset_ff      <= {fields_next.rtp_bytes[8], fields_next.rtp_bytes[9],
                                   fields_next.rtp_bytes[10], fields_next.rtp_bytes[11]};
         end else begin
            source_ip_ff       <= '0;
            dest_ip_ff         <= '0;
            source_port_ff     <= '0;
            dest_port_ff       <= '0;
            rtp_version_ff     <= '0;
            rtp_flag_bits_ff   <= '0;
            contrib_count_ff   <= '0;
            media_type_ff      <= '0;
            seq_number_ff      <= '0;
            rtp_timestamp_ff   <= '0;
            rtp_offset_ff      <= '0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_source_ip       = source_ip_ff;
   assign rsp_dest_ip         = dest_ip_ff;
   assign rsp_source_port     = source_port_ff;
   assign rsp_dest_port       = dest_port_ff;
   assign rsp_rtp_version     = rtp_version_ff;
   assign rsp_rtp_flag_bits   = rtp_flag_bits_ff;
   assign rsp_contrib_count   = contrib_count_ff;
   assign rsp_media_type      = media_type_ff;
   assign rsp_seq_number      = seq_number_ff;
   assign rsp_rtp_timestamp   = rtp_timestamp_ff;
   assign rsp_rtp_offset      = rtp_offset_ff;

endmodule

// ===== rtl/iurhp_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iurhp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_source_ip,
   input logic [31:0] rsp_dest_ip,
   input logic [15:0] rsp_source_port,
   input logic [15:0] rsp_seq_number
);

   logic final_blocked;
   logic final_taken;
   logic result_failed;
   logic fields_clear;

   // Conditions watched by the checks below.
   assign final_blocked = req_valid && req_last_byte && rsp_valid && !rsp_ready;
   assign final_taken   = req_valid && req_ready && req_last_byte;
   assign result_failed = rsp_valid && (rsp_status != iurhp_pkg::STATUS_OK);
   assign fields_clear  = (rsp_source_ip == '0) && (rsp_dest_ip == '0) &&
                          (rsp_source_port == '0) && (rsp_seq_number == '0);

   // A stalled result stays offered.
   `ASSERT_NEXT_CYCLE(rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A final byte is never taken while a result is still held, so none is overwritten.
   `ASSERT_SAME_CYCLE(no_overwrite, clock, reset, final_blocked, !req_ready)

   // Only a final byte produces a result.
   `ASSERT_NEXT_CYCLE(result_needs_last, clock, reset, !rsp_valid && !final_taken, !rsp_valid)

   // A failed packet reports no header fields.
   `ASSERT_SAME_CYCLE(failed_fields_zero, clock, reset, result_failed, fields_clear)

endmodule

bind ipv4_udp_rtp_header_parser iurhp_checker u_checker (.*);
